### hdl/vpid_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpid_pkg
// Shared types, constants and command/status structures of the velocity
// PID inner loop.
// ----------------------------------------------------------------------------
package vpid_pkg;

  localparam int FRAC_BITS = 16;
  localparam int ONE_Q     = 1 << FRAC_BITS;
  localparam int US_PER_S  = 1000000;

  localparam int DATA_W    = 32;
  localparam int TAU_W     = 31;
  localparam int VD_W      = 26;
  localparam int XY_W      = 21;
  localparam int CFG_IDX_W = 2;
  localparam int MUL_W     = 34;
  localparam int PROD_W    = 2 * MUL_W;
  localparam int PQ_W      = 48;            // product after the Q shift
  localparam int ACC_W     = 52;
  localparam int DIV_REM_W = 53;
  localparam int DIV_Q_W   = 32;
  localparam int DIV_CNT_W = 6;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_KP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_KI = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_KD = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LP_TAU    = 2'd3;

  localparam logic [TAU_W-1:0] TAU_RESET = 31'd524;

  // fixed X/Y gains, altitude threshold and loop limits
  localparam logic signed [DATA_W-1:0] XY_KP   = 32'(-4 * ONE_Q);
  localparam logic signed [DATA_W-1:0] XY_KI   = 32'(-((ONE_Q + 500) / 1000));
  localparam logic signed [DATA_W-1:0] XY_KD   = 32'(-((3 * ONE_Q + 5) / 10));
  localparam logic signed [DATA_W-1:0] ALT_MIN = 32'(ONE_Q / 10);
  localparam logic signed [DATA_W-1:0] ILIM_H  = 32'(120 * ONE_Q);
  localparam logic signed [DATA_W-1:0] ILIM_XY = 32'(4 * ONE_Q);
  localparam logic signed [DATA_W-1:0] VD_LO   = 32'(-100 * ONE_Q);
  localparam logic signed [DATA_W-1:0] VD_HI   = 32'(300 * ONE_Q);
  localparam logic signed [DATA_W-1:0] XY_LO   = 32'(-10 * ONE_Q);
  localparam logic signed [DATA_W-1:0] XY_HI   = 32'(10 * ONE_Q);

  typedef enum logic [1:0] {
    LOOP_H,
    LOOP_X,
    LOOP_Y
  } loop_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_TAU_MUL,
    OP_ALPHA_START,
    OP_ALPHA_DONE,
    OP_ERR,
    OP_DIFF,
    OP_MAG_MUL,
    OP_QUOT_START,
    OP_RAW,
    OP_FILT_MUL,
    OP_FILT_UPD,
    OP_STORE_ERR,
    OP_MUL_P,
    OP_MUL_D,
    OP_MUL_I,
    OP_INTEG,
    OP_SUM,
    OP_CLAMP,
    OP_EMIT
  } dp_op_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_TAU,
    S_ASTART,
    S_AWAIT,
    S_ERR,
    S_DIFF,
    S_MAG,
    S_QSTART,
    S_QWAIT,
    S_FMUL,
    S_FUPD,
    S_STORE,
    S_MULP,
    S_MULD,
    S_MULI,
    S_INTEG,
    S_SUM,
    S_CLAMP,
    S_EMIT
  } ctrl_state_t;

  typedef struct packed {
    dp_op_t op;
    loop_t  loop;
  } dp_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic tau_zero;
    logic delta_zero;
    logic xy_active;
    logic out_busy;
  } dp_sts_t;

  function automatic logic signed [ACC_W-1:0] sx_acc(input logic signed [DATA_W-1:0] v);
    return {{(ACC_W-DATA_W){v[DATA_W-1]}}, v};
  endfunction

endpackage

### hdl/velocity_pid_inner_loop.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// velocity_pid_inner_loop
// Velocity inner loop: vertical PID with feedforward plus X/Y PIDs, each
// with a low-pass filtered derivative, signed Q16.16.
//
// Input channel in_*: one item per control tick, taken when in_valid is
// high and in_stall low. in_stall is low only while the sequencer is idle.
// Result channel out_*: one item per input item, held in an output register
// while out_stall is high; the next input item is taken meanwhile, and its
// result waits in the sequencer until the output register is free.
// The two serial divisions (filter coefficient, and per loop the derivative
// quotient) and the shared 34x34 multiplier set the latency.
// Equal timestamps skip the derivative.
// Configuration (cfg_we/cfg_index/cfg_data) is registered at once and also applies to an item in progress.
// Reset (rst_n low, synchronous) clears loop state, timestamp history and
// the output valid, and loads the register defaults.
// ----------------------------------------------------------------------------
module velocity_pid_inner_loop import vpid_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [DATA_W-1:0]        cfg_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [DATA_W-1:0]        in_now_us,
  input  logic signed [DATA_W-1:0] in_height_vel_target,
  input  logic signed [DATA_W-1:0] in_height_vel_measured,
  input  logic signed [DATA_W-1:0] in_height_feedforward,
  input  logic signed [DATA_W-1:0] in_x_vel_target,
  input  logic signed [DATA_W-1:0] in_x_vel_measured,
  input  logic signed [DATA_W-1:0] in_y_vel_target,
  input  logic signed [DATA_W-1:0] in_y_vel_measured,
  input  logic                     in_spot_mode,
  input  logic                     in_optical_flow_mode,
  input  logic signed [DATA_W-1:0] in_altitude,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [VD_W-1:0]   out_vertical_drive,
  output logic signed [XY_W-1:0]   out_roll_target,
  output logic signed [XY_W-1:0]   out_pitch_target,
  output logic                     out_xy_active
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  vpid_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  vpid_datapath u_dp (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cmd                    (cmd),
    .sts                    (sts),
    .cfg_we                 (cfg_we),
    .cfg_index              (cfg_index),
    .cfg_data               (cfg_data),
    .in_now_us              (in_now_us),
    .in_height_vel_target   (in_height_vel_target),
    .in_height_vel_measured (in_height_vel_measured),
    .in_height_feedforward  (in_height_feedforward),
    .in_x_vel_target        (in_x_vel_target),
    .in_x_vel_measured      (in_x_vel_measured),
    .in_y_vel_target        (in_y_vel_target),
    .in_y_vel_measured      (in_y_vel_measured),
    .in_spot_mode           (in_spot_mode),
    .in_optical_flow_mode   (in_optical_flow_mode),
    .in_altitude            (in_altitude),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_vertical_drive     (out_vertical_drive),
    .out_roll_target        (out_roll_target),
    .out_pitch_target       (out_pitch_target),
    .out_xy_active          (out_xy_active)
  );

endmodule

### hdl/vpid_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpid_div
// Restoring divider, one quotient bit per cycle. The partial remainder must
// start below the divisor; dividend bits are shifted in MSB first.
// ----------------------------------------------------------------------------
module vpid_div import vpid_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [DIV_CNT_W-1:0] iters,
  input  logic [DIV_REM_W-1:0] rem_init,
  input  logic [DIV_REM_W-1:0] den,
  input  logic [DIV_Q_W-1:0]   shin,
  output logic                 busy,
  output logic [DIV_Q_W-1:0]   quo
);

  logic                 busy_r, busy_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DIV_REM_W-1:0] rem_r, rem_nxt;
  logic [DIV_REM_W-1:0] den_r;
  logic [DIV_Q_W-1:0]   sh_r;
  logic [DIV_Q_W-1:0]   quo_r;
  logic [DIV_REM_W:0]   trial;
  logic [DIV_REM_W:0]   sub;
  logic                 ge;

  always_comb begin
    trial    = {rem_r, sh_r[DIV_Q_W-1]};
    sub      = trial - {1'b0, den_r};
    ge       = trial >= {1'b0, den_r};
    rem_nxt  = ge ? sub[DIV_REM_W-1:0] : trial[DIV_REM_W-1:0];
    cnt_nxt  = cnt_r - 1'b1;
    busy_nxt = busy_r && (cnt_r != 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= iters;
    end else if (busy_r) begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= rem_init;
      den_r <= den;
      sh_r  <= shin;
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      sh_r  <= {sh_r[DIV_Q_W-2:0], 1'b0};
      quo_r <= {quo_r[DIV_Q_W-2:0], ge};
    end
  end

  assign busy = busy_r;
  assign quo  = quo_r;

endmodule

### hdl/vpid_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpid_datapath
// Registers, shared multiplier, divider, loop state and result register of
// the velocity PID. Driven one command per cycle by the controller.
// ----------------------------------------------------------------------------
module vpid_datapath import vpid_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  dp_cmd_t                  cmd,
  output dp_sts_t                  sts,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [DATA_W-1:0]        cfg_data,
  input  logic [DATA_W-1:0]        in_now_us,
  input  logic signed [DATA_W-1:0] in_height_vel_target,
  input  logic signed [DATA_W-1:0] in_height_vel_measured,
  input  logic signed [DATA_W-1:0] in_height_feedforward,
  input  logic signed [DATA_W-1:0] in_x_vel_target,
  input  logic signed [DATA_W-1:0] in_x_vel_measured,
  input  logic signed [DATA_W-1:0] in_y_vel_target,
  input  logic signed [DATA_W-1:0] in_y_vel_measured,
  input  logic                     in_spot_mode,
  input  logic                     in_optical_flow_mode,
  input  logic signed [DATA_W-1:0] in_altitude,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [VD_W-1:0]   out_vertical_drive,
  output logic signed [XY_W-1:0]   out_roll_target,
  output logic signed [XY_W-1:0]   out_pitch_target,
  output logic                     out_xy_active
);

  localparam int FB = FRAC_BITS;

  // configuration
  logic signed [DATA_W-1:0] kp_r, ki_r, kd_r;
  logic [TAU_W-1:0]         tau_r;

  // timing
  logic              time_valid_r;
  logic [DATA_W-1:0] last_time_r;
  logic [DATA_W-1:0] delta_r;
  logic [FB:0]       alpha_r;

  // captured item
  logic signed [DATA_W-1:0] h_tgt_r, h_meas_r, ff_r, x_tgt_r, x_meas_r, y_tgt_r, y_meas_r;
  logic                     active_r;

  // loop state
  logic signed [DATA_W-1:0] last_err_r [3];
  logic signed [DATA_W-1:0] filt_r     [3];
  logic signed [DATA_W-1:0] integ_r    [3];

  // working registers
  logic signed [DATA_W-1:0] err_r;
  logic [DATA_W:0]          diff_r;
  logic                     ovf_r;
  logic signed [DATA_W-1:0] raw_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [VD_W-1:0]   res_h_r;
  logic signed [XY_W-1:0]   res_x_r, res_y_r;

  logic                     out_valid_r;
  logic signed [VD_W-1:0]   out_vd_r;
  logic signed [XY_W-1:0]   out_roll_r, out_pitch_r;
  logic                     out_act_r;

  // selected loop operands
  logic [1:0]               li;
  logic signed [DATA_W-1:0] tgt, meas, kp, ki, kd, ff, ilim, lo, hi;
  logic signed [DATA_W-1:0] le, fv, iv;

  logic [DATA_W:0]          e33, d33, rf;
  logic signed [DATA_W-1:0] err_c, raw_c, clamp_c;
  logic [DATA_W-1:0]        mag_c, qm_c;
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] mul_p;
  logic signed [PQ_W-1:0]   pq;
  logic signed [DATA_W+1:0] fsum;
  logic signed [PQ_W:0]     isum, ilim_x;
  logic                     ovf_c;

  // divider interface
  logic                 div_start, div_busy;
  logic [DIV_CNT_W-1:0] div_iters;
  logic [DIV_REM_W-1:0] div_rem, div_den;
  logic [DIV_Q_W-1:0]   div_shin, div_quo;

  assign li = cmd.loop;
  assign le = last_err_r[li];
  assign fv = filt_r[li];
  assign iv = integ_r[li];

  always_comb begin
    case (cmd.loop)
      LOOP_X: begin
        tgt = x_tgt_r; meas = x_meas_r; kp = XY_KP; ki = XY_KI; kd = XY_KD;
        ff = '0; ilim = ILIM_XY; lo = XY_LO; hi = XY_HI;
      end
      LOOP_Y: begin
        tgt = y_tgt_r; meas = y_meas_r; kp = XY_KP; ki = XY_KI; kd = XY_KD;
        ff = '0; ilim = ILIM_XY; lo = XY_LO; hi = XY_HI;
      end
      default: begin
        tgt = h_tgt_r; meas = h_meas_r; kp = kp_r; ki = ki_r; kd = kd_r;
        ff = ff_r; ilim = ILIM_H; lo = VD_LO; hi = VD_HI;
      end
    endcase
  end

  always_comb begin
    // saturating error
    e33 = {tgt[DATA_W-1], tgt} - {meas[DATA_W-1], meas};
    if (e33[DATA_W] != e33[DATA_W-1])
      err_c = e33[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    else
      err_c = e33[DATA_W-1:0];

    d33   = {err_r[DATA_W-1], err_r} - {le[DATA_W-1], le};
    mag_c = diff_r[DATA_W] ? DATA_W'(~diff_r + 1'b1) : diff_r[DATA_W-1:0];

    // quotient overflows 32 bits when the upper dividend bits reach the divisor
    ovf_c = {11'b0, prod_r[DIV_REM_W-1:DATA_W]} >= delta_r;

    qm_c  = (ovf_r || div_quo > 32'h8000_0000) ? 32'h8000_0000 : div_quo;
    if (diff_r[DATA_W])
      raw_c = -qm_c;
    else
      raw_c = qm_c[DATA_W-1] ? 32'h7FFF_FFFF : qm_c;

    rf   = {raw_r[DATA_W-1], raw_r} - {fv[DATA_W-1], fv};
    pq   = prod_r[FB+PQ_W-1:FB];
    fsum = {{2{fv[DATA_W-1]}}, fv} + prod_r[FB+DATA_W+1:FB];

    isum   = {{(PQ_W+1-DATA_W){iv[DATA_W-1]}}, iv} + {pq[PQ_W-1], pq};
    ilim_x = {{(PQ_W+1-DATA_W){ilim[DATA_W-1]}}, ilim};

    if (acc_r < sx_acc(lo))      clamp_c = lo;
    else if (acc_r > sx_acc(hi)) clamp_c = hi;
    else                         clamp_c = acc_r[DATA_W-1:0];
  end

  // shared multiplier operand select
  always_comb begin
    case (cmd.op)
      OP_TAU_MUL: begin
        mul_a = {3'b0, tau_r};
        mul_b = MUL_W'(US_PER_S);
      end
      OP_MAG_MUL: begin
        mul_a = {2'b0, mag_c};
        mul_b = MUL_W'(US_PER_S);
      end
      OP_FILT_MUL: begin
        mul_a = {{(MUL_W-FB-1){1'b0}}, alpha_r};
        mul_b = {rf[DATA_W], rf};
      end
      OP_MUL_P: begin
        mul_a = {{2{err_r[DATA_W-1]}}, err_r};
        mul_b = {{2{kp[DATA_W-1]}}, kp};
      end
      OP_MUL_D: begin
        mul_a = {{2{fv[DATA_W-1]}}, fv};
        mul_b = {{2{kd[DATA_W-1]}}, kd};
      end
      OP_MUL_I: begin
        mul_a = {{2{err_r[DATA_W-1]}}, err_r};
        mul_b = {{2{ki[DATA_W-1]}}, ki};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // divider set-up: filter coefficient or derivative quotient
  always_comb begin
    if (cmd.op == OP_ALPHA_START) begin
      div_start = (tau_r != '0);
      div_iters = DIV_CNT_W'(FB);
      div_rem   = DIV_REM_W'(delta_r) << FB;
      div_den   = prod_r[DIV_REM_W-1:0] + (DIV_REM_W'(delta_r) << FB);
      div_shin  = '0;
    end else begin
      div_start = (cmd.op == OP_QUOT_START) && !ovf_c;
      div_iters = DIV_CNT_W'(DIV_Q_W);
      div_rem   = {{(DIV_REM_W-21){1'b0}}, prod_r[DIV_REM_W-1:DATA_W]};
      div_den   = DIV_REM_W'(delta_r);
      div_shin  = prod_r[DATA_W-1:0];
    end
  end

  vpid_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .iters    (div_iters),
    .rem_init (div_rem),
    .den      (div_den),
    .shin     (div_shin),
    .busy     (div_busy),
    .quo      (div_quo)
  );

  // control state, configuration, loop state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r         <= '0;
      ki_r         <= '0;
      kd_r         <= '0;
      tau_r        <= TAU_RESET;
      time_valid_r <= 1'b0;
      last_time_r  <= '0;
      out_valid_r  <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        last_err_r[k] <= '0;
        filt_r[k]     <= '0;
        integ_r[k]    <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_HEIGHT_KP: kp_r  <= cfg_data;
          CFG_HEIGHT_KI: ki_r  <= cfg_data;
          CFG_HEIGHT_KD: kd_r  <= cfg_data;
          CFG_LP_TAU:    tau_r <= cfg_data[TAU_W-1:0];
          default: ;
        endcase
      end
      case (cmd.op)
        OP_LOAD: begin
          time_valid_r <= 1'b1;
          last_time_r  <= in_now_us;
        end
        OP_FILT_UPD:  filt_r[li]     <= fsum[DATA_W-1:0];
        OP_STORE_ERR: last_err_r[li] <= err_r;
        OP_INTEG: begin
          if (isum < -ilim_x)    integ_r[li] <= -ilim;
          else if (isum > ilim_x) integ_r[li] <= ilim;
          else                    integ_r[li] <= isum[DATA_W-1:0];
        end
        default: ;
      endcase
      if (cmd.op == OP_EMIT)
        out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall)
        out_valid_r <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_TAU_MUL, OP_MAG_MUL, OP_FILT_MUL, OP_MUL_P, OP_MUL_I: prod_r <= mul_p;
      OP_MUL_D: begin
        prod_r <= mul_p;
        acc_r  <= {{(ACC_W-PQ_W){pq[PQ_W-1]}}, pq} + sx_acc(ff);
      end
      default: ;
    endcase
    case (cmd.op)
      OP_LOAD: begin
        delta_r  <= time_valid_r ? in_now_us - last_time_r : DATA_W'(US_PER_S);
        h_tgt_r  <= in_height_vel_target;
        h_meas_r <= in_height_vel_measured;
        ff_r     <= in_height_feedforward;
        x_tgt_r  <= in_x_vel_target;
        x_meas_r <= in_x_vel_measured;
        y_tgt_r  <= in_y_vel_target;
        y_meas_r <= in_y_vel_measured;
        active_r <= in_spot_mode && !in_optical_flow_mode && (in_altitude > ALT_MIN);
        res_x_r  <= '0;
        res_y_r  <= '0;
      end
      OP_ALPHA_START: if (tau_r == '0) alpha_r <= (FB+1)'(ONE_Q);
      OP_ALPHA_DONE:  alpha_r <= {1'b0, div_quo[FB-1:0]};
      OP_ERR:         err_r   <= err_c;
      OP_DIFF:        diff_r  <= d33;
      OP_QUOT_START:  ovf_r   <= ovf_c;
      OP_RAW:         raw_r   <= raw_c;
      OP_MUL_I:       acc_r   <= acc_r + {{(ACC_W-PQ_W){pq[PQ_W-1]}}, pq};
      OP_SUM:         acc_r   <= acc_r + sx_acc(iv);
      OP_CLAMP: begin
        case (cmd.loop)
          LOOP_X:  res_x_r <= clamp_c[XY_W-1:0];
          LOOP_Y:  res_y_r <= clamp_c[XY_W-1:0];
          default: res_h_r <= clamp_c[VD_W-1:0];
        endcase
      end
      OP_EMIT: begin
        out_vd_r    <= res_h_r;
        out_roll_r  <= res_x_r;
        out_pitch_r <= res_y_r;
        out_act_r   <= active_r;
      end
      default: ;
    endcase
  end

  assign sts.div_busy   = div_busy;
  assign sts.tau_zero   = (tau_r == '0);
  assign sts.delta_zero = (delta_r == '0);
  assign sts.xy_active  = active_r;
  assign sts.out_busy   = out_valid_r && out_stall;

  assign out_valid          = out_valid_r;
  assign out_vertical_drive = out_vd_r;
  assign out_roll_target    = out_roll_r;
  assign out_pitch_target   = out_pitch_r;
  assign out_xy_active      = out_act_r;

endmodule

### hdl/vpid_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpid_ctrl
// Sequencer of the velocity PID: walks the datapath through timing, filter
// coefficient, height loop and, if active, the X/Y loops; one command per cycle.
// ----------------------------------------------------------------------------
module vpid_ctrl import vpid_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  ctrl_state_t state_r, state_nxt;
  loop_t       loop_r, loop_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      loop_r  <= LOOP_H;
    end else begin
      state_r <= state_nxt;
      loop_r  <= loop_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    loop_nxt  = loop_r;
    cmd.op    = OP_NONE;
    cmd.loop  = loop_r;
    in_stall  = 1'b1;
    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          loop_nxt  = LOOP_H;
          state_nxt = S_TAU;
        end
      end
      S_TAU: begin
        cmd.op    = OP_TAU_MUL;
        state_nxt = S_ASTART;
      end
      S_ASTART: begin
        cmd.op    = OP_ALPHA_START;
        state_nxt = sts.tau_zero ? S_ERR : S_AWAIT;
      end
      S_AWAIT: begin
        if (!sts.div_busy) begin
          cmd.op    = OP_ALPHA_DONE;
          state_nxt = S_ERR;
        end
      end
      S_ERR: begin
        cmd.op    = OP_ERR;
        state_nxt = S_DIFF;
      end
      S_DIFF: begin
        cmd.op    = OP_DIFF;
        // equal timestamps hold the filtered derivative
        state_nxt = sts.delta_zero ? S_STORE : S_MAG;
      end
      S_MAG: begin
        cmd.op    = OP_MAG_MUL;
        state_nxt = S_QSTART;
      end
      S_QSTART: begin
        cmd.op    = OP_QUOT_START;
        state_nxt = S_QWAIT;
      end
      S_QWAIT: begin
        if (!sts.div_busy) begin
          cmd.op    = OP_RAW;
          state_nxt = S_FMUL;
        end
      end
      S_FMUL: begin
        cmd.op    = OP_FILT_MUL;
        state_nxt = S_FUPD;
      end
      S_FUPD: begin
        cmd.op    = OP_FILT_UPD;
        state_nxt = S_STORE;
      end
      S_STORE: begin
        cmd.op    = OP_STORE_ERR;
        state_nxt = S_MULP;
      end
      S_MULP: begin
        cmd.op    = OP_MUL_P;
        state_nxt = S_MULD;
      end
      S_MULD: begin
        cmd.op    = OP_MUL_D;
        state_nxt = S_MULI;
      end
      S_MULI: begin
        cmd.op    = OP_MUL_I;
        state_nxt = S_INTEG;
      end
      S_INTEG: begin
        cmd.op    = OP_INTEG;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        cmd.op    = OP_SUM;
        state_nxt = S_CLAMP;
      end
      S_CLAMP: begin
        cmd.op = OP_CLAMP;
        if (loop_r == LOOP_H && sts.xy_active) begin
          loop_nxt  = LOOP_X;
          state_nxt = S_ERR;
        end else if (loop_r == LOOP_X) begin
          loop_nxt  = LOOP_Y;
          state_nxt = S_ERR;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!sts.out_busy) begin
          cmd.op    = OP_EMIT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

### hdl/vpid_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpid_checker
// Port-level checks of the velocity PID: result ranges, inactive X/Y
// outputs, reset and stalled result behaviour.
// ----------------------------------------------------------------------------
module vpid_checker import vpid_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_valid,
  input logic                   out_stall,
  input logic signed [VD_W-1:0] out_vertical_drive,
  input logic signed [XY_W-1:0] out_roll_target,
  input logic signed [XY_W-1:0] out_pitch_target,
  input logic                   out_xy_active
);

  a_rst_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_vertical_drive)
      && $stable(out_roll_target) && $stable(out_pitch_target))
    else $error("stalled result changed");

  a_vd_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_vertical_drive >= VD_LO && out_vertical_drive <= VD_HI)
    else $error("vertical drive out of range");

  a_xy_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_roll_target >= XY_LO && out_roll_target <= XY_HI
      && out_pitch_target >= XY_LO && out_pitch_target <= XY_HI)
    else $error("roll or pitch out of range");

  a_xy_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_xy_active |-> out_roll_target == '0 && out_pitch_target == '0)
    else $error("X/Y output non-zero while inactive");

endmodule

bind velocity_pid_inner_loop vpid_checker u_vpid_checker (.*);
